FILE: hdl/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared constants and types for the huffman stream decoder: table geometry,
// request kinds, register indexes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hsd_pkg;

   // table and field geometry
   localparam int NODE_COUNT   = 256;
   localparam int NODE_AW      = $clog2(NODE_COUNT);
   localparam int SYMBOL_WIDTH = 8;
   localparam int COUNT_WIDTH  = 24;
   localparam int BYTE_BITS    = 8;
   localparam int BIT_CNT_W    = $clog2(BYTE_BITS + 1);

   // configuration port
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam logic REG_SYMBOL_TOTAL = 1'b0;
   localparam logic REG_ROOT_SLOT    = 1'b1;

   // request kinds
   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_BYTE    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_CHILD
   } state_type;

   // one node table entry
   typedef struct packed {
      logic                    leaf;
      logic [SYMBOL_WIDTH-1:0] symbol;
      logic [NODE_AW-1:0]      zero_child;
      logic [NODE_AW-1:0]      one_child;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load_entry;
      logic restart;
      logic accept_byte;
      logic drop_bit;
      logic descend;
      logic emit;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cur_leaf;
      logic total_hit;
      logic bits_done;
   } status_type;

   // register file to datapath
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] symbol_total;
      logic [NODE_AW-1:0]     root_slot;
      logic                   root_wr;
      logic [NODE_AW-1:0]     root_new;
   } csr_type;

endpackage

FILE: hdl/hsd_csr.sv
// ----------------------------------------------------------------------------
// hsd_csr
// Configuration registers: symbol total and root slot, written and read
// through a simple APB-style port with zero wait states.
// ----------------------------------------------------------------------------
module hsd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [hsd_pkg::CSR_AW-1:0]    paddr,
   input  logic [hsd_pkg::CSR_DW-1:0]    pwdata,
   output logic [hsd_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   output hsd_pkg::csr_type              csr
);

   logic                                 wr_en;
   logic [hsd_pkg::COUNT_WIDTH-1:0]      total_ff, total_in;
   logic [hsd_pkg::NODE_AW-1:0]          root_ff, root_in;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // register writes
   always_comb begin
      total_in = total_ff;
      root_in  = root_ff;
      if (wr_en) begin
         unique case (paddr[2])
            hsd_pkg::REG_SYMBOL_TOTAL: total_in = pwdata[hsd_pkg::COUNT_WIDTH-1:0];
            hsd_pkg::REG_ROOT_SLOT:    root_in  = pwdata[hsd_pkg::NODE_AW-1:0];
            default:                   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         root_ff  <= '0;
      end else begin
         total_ff <= total_in;
         root_ff  <= root_in;
      end
   end

   // read mux
   always_comb begin
      unique case (paddr[2])
         hsd_pkg::REG_SYMBOL_TOTAL: prdata = hsd_pkg::CSR_DW'(total_ff);
         hsd_pkg::REG_ROOT_SLOT:    prdata = hsd_pkg::CSR_DW'(root_ff);
         default:                   prdata = '0;
      endcase
   end

   // a root write also moves the walker
   assign csr.symbol_total = total_ff;
   assign csr.root_slot    = root_ff;
   assign csr.root_wr      = wr_en && (paddr[2] == hsd_pkg::REG_ROOT_SLOT);
   assign csr.root_new     = pwdata[hsd_pkg::NODE_AW-1:0];

endmodule

FILE: hdl/hsd_ctrl.sv
// ----------------------------------------------------------------------------
// hsd_ctrl
// Walk controller: dispatches requests, then steps through the bits of a
// compressed byte one node-table read at a time.
// ----------------------------------------------------------------------------
module hsd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            kind,
   input  hsd_pkg::status_type   status,
   output hsd_pkg::cmd_type      cmd,
   output logic                  busy
);

   hsd_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hsd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != hsd_pkg::ST_IDLE);
      unique case (state_ff)
         hsd_pkg::ST_IDLE: begin
            if (start) begin
               unique case (kind)
                  hsd_pkg::KIND_LOAD:    cmd.load_entry = 1'b1;
                  hsd_pkg::KIND_RESTART: cmd.restart    = 1'b1;
                  hsd_pkg::KIND_BYTE: begin
                     cmd.accept_byte = 1'b1;
                     state_in        = hsd_pkg::ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         // current entry is in the read register
         hsd_pkg::ST_WALK: begin
            priority if (status.total_hit || status.bits_done) begin
               cmd.finish = 1'b1;
               state_in   = hsd_pkg::ST_IDLE;
            end else if (status.cur_leaf) begin
               cmd.drop_bit = 1'b1;
            end else begin
               cmd.descend = 1'b1;
               state_in    = hsd_pkg::ST_CHILD;
            end
         end
         // freshly read child: leaf emits; inner node stops or descends at once
         hsd_pkg::ST_CHILD: begin
            priority if (status.cur_leaf) begin
               cmd.emit = 1'b1;
               state_in = hsd_pkg::ST_WALK;
            end else if (status.total_hit || status.bits_done) begin
               cmd.finish = 1'b1;
               state_in   = hsd_pkg::ST_IDLE;
            end else begin
               cmd.descend = 1'b1;
            end
         end
         default: state_in = hsd_pkg::ST_IDLE;
      endcase
   end

endmodule

FILE: hdl/hsd_datapath.sv
// ----------------------------------------------------------------------------
// hsd_datapath
// Node table memory, walker registers, symbol counter and the one-deep
// holding stage that lets the last symbol of a byte carry its run-end flag.
// ----------------------------------------------------------------------------
module hsd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  hsd_pkg::cmd_type                    cmd,
   input  hsd_pkg::csr_type                    csr,
   input  logic [7:0]                          node_slot,
   input  logic                                leaf_mark,
   input  logic [7:0]                          leaf_symbol,
   input  logic [7:0]                          zero_branch,
   input  logic [7:0]                          one_branch,
   input  logic [7:0]                          stream_byte,
   output hsd_pkg::status_type                 status,
   output logic                                out_valid,
   output logic [7:0]                          out_symbol,
   output logic                                out_final,
   output logic                                out_run_end
);

   hsd_pkg::entry_type                   node_mem [hsd_pkg::NODE_COUNT];
   hsd_pkg::entry_type                   rd_ff;
   hsd_pkg::entry_type                   wr_entry;
   logic                                 rd_en;
   logic [hsd_pkg::NODE_AW-1:0]          rd_addr;
   logic [hsd_pkg::NODE_AW-1:0]          child;

   logic [hsd_pkg::NODE_AW-1:0]          cur_node_ff, cur_node_in;
   logic [7:0]                           byte_ff, byte_in;
   logic [hsd_pkg::BIT_CNT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [hsd_pkg::COUNT_WIDTH-1:0]      count_ff, count_in, count_inc;

   logic                                 pend_valid_ff, pend_valid_in;
   logic [hsd_pkg::SYMBOL_WIDTH-1:0]     pend_sym_ff, pend_sym_in;
   logic                                 pend_final_ff, pend_final_in;

   logic                                 out_valid_ff, out_valid_in;
   logic [hsd_pkg::SYMBOL_WIDTH-1:0]     out_sym_ff, out_sym_in;
   logic                                 out_final_ff, out_final_in;
   logic                                 out_end_ff, out_end_in;

   // node table write and registered read
   assign wr_entry.leaf       = leaf_mark;
   assign wr_entry.symbol     = leaf_symbol[hsd_pkg::SYMBOL_WIDTH-1:0];
   assign wr_entry.zero_child = zero_branch[hsd_pkg::NODE_AW-1:0];
   assign wr_entry.one_child  = one_branch[hsd_pkg::NODE_AW-1:0];

   assign child   = byte_ff[hsd_pkg::BYTE_BITS-1] ? rd_ff.one_child : rd_ff.zero_child;
   assign rd_en   = cmd.accept_byte || cmd.descend || cmd.emit;

   always_comb begin
      priority if (cmd.accept_byte) rd_addr = cur_node_ff;
      else if (cmd.descend)         rd_addr = child;
      else                          rd_addr = csr.root_slot;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_entry) begin
         node_mem[node_slot[hsd_pkg::NODE_AW-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         rd_ff <= node_mem[rd_addr];
      end
   end

   // status to controller
   assign status.cur_leaf  = rd_ff.leaf;
   assign status.total_hit = (count_ff >= csr.symbol_total);
   assign status.bits_done = (bit_cnt_ff == hsd_pkg::BIT_CNT_W'(hsd_pkg::BYTE_BITS));

   // walker, bit shifter and symbol counter
   assign count_inc = count_ff + hsd_pkg::COUNT_WIDTH'(1);

   always_comb begin
      cur_node_in = cur_node_ff;
      byte_in     = byte_ff;
      bit_cnt_in  = bit_cnt_ff;
      count_in    = count_ff;
      priority if (csr.root_wr) cur_node_in = csr.root_new;
      else if (cmd.restart || cmd.emit) cur_node_in = csr.root_slot;
      else if (cmd.descend) cur_node_in = child;
      if (cmd.accept_byte) begin
         byte_in    = stream_byte;
         bit_cnt_in = '0;
      end else if (cmd.drop_bit || cmd.descend) begin
         byte_in    = {byte_ff[hsd_pkg::BYTE_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + hsd_pkg::BIT_CNT_W'(1);
      end
      if (cmd.restart) begin
         count_in = '0;
      end else if (cmd.emit) begin
         count_in = count_inc;
      end
   end

   // hold each symbol until the next one or the end of the byte shows
   // whether it closes the run
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_final_in = pend_final_ff;
      out_valid_in  = 1'b0;
      out_sym_in    = pend_sym_ff;
      out_final_in  = pend_final_ff;
      out_end_in    = 1'b0;
      if (cmd.emit) begin
         out_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_sym_in   = rd_ff.symbol;
         pend_final_in = (count_inc == csr.symbol_total);
      end else if (cmd.finish) begin
         out_valid_in  = pend_valid_ff;
         out_end_in    = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_node_ff   <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cur_node_ff   <= cur_node_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      bit_cnt_ff    <= bit_cnt_in;
      pend_sym_ff   <= pend_sym_in;
      pend_final_ff <= pend_final_in;
      out_sym_ff    <= out_sym_in;
      out_final_ff  <= out_final_in;
      out_end_ff    <= out_end_in;
   end

   assign out_valid   = out_valid_ff;
   assign out_symbol  = 8'(out_sym_ff);
   assign out_final   = out_final_ff;
   assign out_run_end = out_end_ff;

endmodule

FILE: hdl/huffman_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_stream_decoder_top
// Huffman stream decoder that walks a code tree held in a 256-entry table.
// ----------------------------------------------------------------------------
// Load and restart requests never raise busy. A compressed byte keeps busy
// high while its bits are walked and through a closing step. Each symbol
// decoded adds a step (the walk back to the root needs another read of the
// single-port node table). The walk closes early once symbol_total is
// reached, and at once when the total was already reached before the
// byte. Each bit that descends waits on a registered read of the node table
// before the next child can be chosen.
// Decoded symbols come out on rsp_valid for one cycle each and cannot be held
// off; the last symbol of a byte is flagged by rsp_run_end and may appear in
// the first idle cycle after busy falls. Decoding stops once symbol_total
// symbols have been produced, until a restart request. Write the registers
// only while busy is low and no symbol is still due.
// ----------------------------------------------------------------------------
module huffman_stream_decoder_top (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_kind,
   input  logic [7:0]                    req_node_slot,
   input  logic                          req_leaf_mark,
   input  logic [7:0]                    req_leaf_symbol,
   input  logic [7:0]                    req_zero_branch,
   input  logic [7:0]                    req_one_branch,
   input  logic [7:0]                    req_stream_byte,
   // result channel
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_symbol,
   output logic                          rsp_final_symbol,
   output logic                          rsp_run_end,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [hsd_pkg::CSR_AW-1:0]    paddr,
   input  logic [hsd_pkg::CSR_DW-1:0]    pwdata,
   output logic [hsd_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   hsd_pkg::csr_type    csr;
   hsd_pkg::cmd_type    cmd;
   hsd_pkg::status_type status;

   // configuration registers
   hsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   // walk controller
   hsd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .kind   (req_kind),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // table, walker and result stage
   hsd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr         (csr),
      .node_slot   (req_node_slot),
      .leaf_mark   (req_leaf_mark),
      .leaf_symbol (req_leaf_symbol),
      .zero_branch (req_zero_branch),
      .one_branch  (req_one_branch),
      .stream_byte (req_stream_byte),
      .status      (status),
      .out_valid   (rsp_valid),
      .out_symbol  (rsp_symbol),
      .out_final   (rsp_final_symbol),
      .out_run_end (rsp_run_end)
   );

endmodule

FILE: hdl/hsd_checker.sv
// ----------------------------------------------------------------------------
// hsd_checker
// Port-level checks on the decoder's result sequencing and busy behavior.
// ----------------------------------------------------------------------------
module hsd_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [1:0] req_kind,
   input  logic       rsp_valid,
   input  logic       rsp_final_symbol,
   input  logic       rsp_run_end
);

   // the symbol that reaches the total always closes its byte
   a_final_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_symbol |-> rsp_run_end)
      else $error("final symbol without run end");

   // a symbol that is not the last one shows up while the byte is still walked
   a_mid_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |-> busy)
      else $error("mid-run symbol outside a byte walk");

   // nothing follows the end of a run directly
   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_end |=> !rsp_valid)
      else $error("symbol right after run end");

   // an accepted byte always starts a walk
   a_byte_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_kind == hsd_pkg::KIND_BYTE) |=> busy)
      else $error("byte accepted without walk");

endmodule

bind huffman_stream_decoder_top hsd_checker u_hsd_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_kind         (req_kind),
   .rsp_valid        (rsp_valid),
   .rsp_final_symbol (rsp_final_symbol),
   .rsp_run_end      (rsp_run_end)
);

FILE: verif/tb_huffman_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_stream_decoder_top
// Self-checking bench for the huffman stream decoder. A 64-slot window of the
// node table (the low and the high 32 slots) is preloaded, then a directed
// pass hits a hand-built tree and the stop cases. After that, random
// load/byte/restart traffic inside the window runs under several register
// settings and idle patterns. A scoreboard walks its own copy of the tree and
// checks every decoded symbol in order.
// ----------------------------------------------------------------------------
module tb_huffman_stream_decoder_top;

   localparam int          CLK_PERIOD    = 10;
   localparam int          SETTLE_CYCLES = 24;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          TREE_SLOTS    = 64;
   localparam logic [1:0]  KIND_UNUSED   = 2'd3;
   localparam logic [23:0] TOTAL_MAX     = 24'hFFFFFF;

   // one request as presented on the req_ ports
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] node_slot;
      logic       leaf_mark;
      logic [7:0] leaf_symbol;
      logic [7:0] zero_branch;
      logic [7:0] one_branch;
      logic [7:0] stream_byte;
   } request_type;

   // one decoded symbol as seen on the rsp_ ports
   typedef struct packed {
      logic [hsd_pkg::SYMBOL_WIDTH-1:0] symbol;
      logic                             final_symbol;
      logic                             run_end;
   } symbol_result_type;

   // tree walker copy plus the queue of symbols still due
   class symbol_scoreboard_type;
      hsd_pkg::entry_type              tree [hsd_pkg::NODE_COUNT];
      logic [hsd_pkg::NODE_AW-1:0]     walker;
      logic [hsd_pkg::NODE_AW-1:0]     root;
      logic [hsd_pkg::COUNT_WIDTH-1:0] emitted;
      logic [hsd_pkg::COUNT_WIDTH-1:0] total;
      symbol_result_type               pending_symbols [$];
      int unsigned                     fail_count;
      int unsigned                     symbols_checked;

      function new();
         walker          = '0;
         root            = '0;
         emitted         = '0;
         total           = '0;
         fail_count      = 0;
         symbols_checked = 0;
      endfunction

      task report_mismatch(string what);
         fail_count++;
         if (fail_count <= 40) begin
            $display("ERROR @%0t: %s", $time, what);
         end
      endtask

      function void set_register(logic idx, logic [hsd_pkg::CSR_DW-1:0] value);
         if (idx == hsd_pkg::REG_SYMBOL_TOTAL) begin
            total = value[hsd_pkg::COUNT_WIDTH-1:0];
         end else begin
            // a new root also moves the walker there
            root   = value[hsd_pkg::NODE_AW-1:0];
            walker = root;
         end
      endfunction

      // walk one byte msb first, queue the symbols it yields
      function void decode_byte(logic [7:0] bits);
         hsd_pkg::entry_type cur;
         hsd_pkg::entry_type nxt;
         symbol_result_type  batch [hsd_pkg::BYTE_BITS];
         int                 n;
         n = 0;
         for (int i = hsd_pkg::BYTE_BITS - 1; i >= 0; i--) begin
            if (emitted >= total) break;
            cur = tree[walker];
            // walker parked on a leaf drops the bit
            if (cur.leaf) continue;
            walker = bits[i] ? cur.one_child : cur.zero_child;
            nxt    = tree[walker];
            if (nxt.leaf) begin
               emitted               = emitted + 1'b1;
               batch[n].symbol       = nxt.symbol;
               batch[n].final_symbol = (emitted == total);
               batch[n].run_end      = 1'b0;
               n++;
               walker = root;
            end
         end
         if (n > 0) batch[n-1].run_end = 1'b1;
         for (int k = 0; k < n; k++) pending_symbols.push_back(batch[k]);
      endfunction

      function void note_request(request_type r);
         case (r.kind)
            hsd_pkg::KIND_LOAD: begin
               tree[r.node_slot].leaf       = r.leaf_mark;
               tree[r.node_slot].symbol     = r.leaf_symbol;
               tree[r.node_slot].zero_child = r.zero_branch;
               tree[r.node_slot].one_child  = r.one_branch;
            end
            hsd_pkg::KIND_RESTART: begin
               walker  = root;
               emitted = '0;
            end
            hsd_pkg::KIND_BYTE: decode_byte(r.stream_byte);
            default: ;
         endcase
      endfunction

      task check_symbol(logic [7:0] sym, logic fin, logic last);
         symbol_result_type want;
         symbols_checked++;
         if (pending_symbols.size() == 0) begin
            report_mismatch($sformatf("symbol %02h arrived with none expected", sym));
         end else begin
            want = pending_symbols.pop_front();
            if (sym !== want.symbol)
               report_mismatch($sformatf("symbol %02h, expected %02h", sym, want.symbol));
            if (fin !== want.final_symbol)
               report_mismatch($sformatf("final_symbol %b, expected %b (symbol %02h)",
                                         fin, want.final_symbol, want.symbol));
            if (last !== want.run_end)
               report_mismatch($sformatf("run_end %b, expected %b (symbol %02h)",
                                         last, want.run_end, want.symbol));
         end
      endtask
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [1:0]                   req_kind;
   logic [7:0]                   req_node_slot;
   logic                         req_leaf_mark;
   logic [7:0]                   req_leaf_symbol;
   logic [7:0]                   req_zero_branch;
   logic [7:0]                   req_one_branch;
   logic [7:0]                   req_stream_byte;
   logic                         rsp_valid;
   logic [7:0]                   rsp_symbol;
   logic                         rsp_final_symbol;
   logic                         rsp_run_end;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [hsd_pkg::CSR_AW-1:0]   paddr;
   logic [hsd_pkg::CSR_DW-1:0]   pwdata;
   logic [hsd_pkg::CSR_DW-1:0]   prdata;
   logic                         pready;

   symbol_scoreboard_type sb;
   int unsigned           cycle_count = 0;
   int unsigned           n_requests  = 0;
   int unsigned           n_bytes     = 0;
   int unsigned           n_loads     = 0;
   int unsigned           n_restarts  = 0;
   int unsigned           n_settings  = 0;
   int unsigned           quiet_left  = 0;

   huffman_stream_decoder_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_node_slot    (req_node_slot),
      .req_leaf_mark    (req_leaf_mark),
      .req_leaf_symbol  (req_leaf_symbol),
      .req_zero_branch  (req_zero_branch),
      .req_one_branch   (req_one_branch),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_symbol       (rsp_symbol),
      .rsp_final_symbol (rsp_final_symbol),
      .rsp_run_end      (rsp_run_end),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // clock
   always #(CLK_PERIOD / 2) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL huffman_stream_decoder_top");
         $finish;
      end
   end

   // symbol monitor, results cannot be held off
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (rsp_valid === 1'b1) begin
            sb.check_symbol(rsp_symbol, rsp_final_symbol, rsp_run_end);
         end else if (rsp_valid !== 1'b0) begin
            sb.report_mismatch("rsp_valid is unknown");
         end
      end
   end

   // k-th slot of the tree window: low 32 slots, then high 32 slots
   function logic [7:0] tree_slot(int k);
      logic [5:0] k6;
      k6 = 6'(k);
      return k6[5] ? {3'b111, k6[4:0]} : {3'b000, k6[4:0]};
   endfunction

   function logic [7:0] random_slot();
      return tree_slot(int'($urandom_range(TREE_SLOTS - 1)));
   endfunction

   function request_type make_load(logic [7:0] slot, logic leaf, logic [7:0] sym,
                                   logic [7:0] zero_slot, logic [7:0] one_slot);
      request_type r;
      r.kind        = hsd_pkg::KIND_LOAD;
      r.node_slot   = slot;
      r.leaf_mark   = leaf;
      r.leaf_symbol = sym;
      r.zero_branch = zero_slot;
      r.one_branch  = one_slot;
      r.stream_byte = 8'($urandom_range(255));
      return r;
   endfunction

   function request_type make_byte(logic [7:0] bits);
      request_type r;
      r             = make_load(8'($urandom_range(255)), 1'($urandom_range(1)),
                                8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)));
      r.kind        = hsd_pkg::KIND_BYTE;
      r.stream_byte = bits;
      return r;
   endfunction

   function request_type make_ctl(logic [1:0] kind);
      request_type r;
      r      = make_byte(8'($urandom_range(255)));
      r.kind = kind;
      return r;
   endfunction

   // mostly bytes, with loads, restarts and the odd unused kind mixed in
   function request_type random_request(int restart_pct);
      request_type r;
      int          pick;
      pick = int'($urandom_range(99));
      r    = make_byte(8'($urandom_range(255)));
      if (pick < restart_pct)
         r.kind = hsd_pkg::KIND_RESTART;
      else if (pick < restart_pct + 4)
         r.kind = KIND_UNUSED;
      else if (pick < restart_pct + 26)
         r = make_load(random_slot(), 1'($urandom_range(1)), 8'($urandom_range(255)),
                       random_slot(), random_slot());
      return r;
   endfunction

   function logic [7:0] pick_internal_root();
      logic [7:0] slot;
      slot = random_slot();
      for (int tries = 0; tries < 64 && sb.tree[slot].leaf; tries++)
         slot = random_slot();
      return slot;
   endfunction

   // hold the request until accepted, leaves start high
   task send_request(request_type r);
      req_kind        <= r.kind;
      req_node_slot   <= r.node_slot;
      req_leaf_mark   <= r.leaf_mark;
      req_leaf_symbol <= r.leaf_symbol;
      req_zero_branch <= r.zero_branch;
      req_one_branch  <= r.one_branch;
      req_stream_byte <= r.stream_byte;
      start           <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_request(r);
      n_requests++;
      if (r.kind == hsd_pkg::KIND_BYTE) n_bytes++;
      if (r.kind == hsd_pkg::KIND_LOAD) n_loads++;
      if (r.kind == hsd_pkg::KIND_RESTART) n_restarts++;
   endtask

   // stop sending and wait until every due symbol has come out
   task drain_symbols();
      start <= 1'b0;
      @(posedge clock);
      while (busy !== 1'b0 || sb.pending_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write followed by a read back
   task write_register(logic idx, logic [hsd_pkg::CSR_DW-1:0] value);
      logic [hsd_pkg::CSR_DW-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      sb.set_register(idx, value);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == hsd_pkg::REG_SYMBOL_TOTAL) begin
         if (readback[hsd_pkg::COUNT_WIDTH-1:0] !== value[hsd_pkg::COUNT_WIDTH-1:0])
            sb.report_mismatch($sformatf("symbol_total reads %h, wrote %h",
                                         readback, value));
      end else begin
         if (readback[hsd_pkg::NODE_AW-1:0] !== value[hsd_pkg::NODE_AW-1:0])
            sb.report_mismatch($sformatf("root_slot reads %h, wrote %h", readback, value));
      end
      // idle bus between transfers
      @(posedge clock);
   endtask

   // new register setting on an idle block, then a fresh stream
   task configure(logic [23:0] total, logic [7:0] root);
      drain_symbols();
      write_register(hsd_pkg::REG_SYMBOL_TOTAL, {8'h00, total});
      write_register(hsd_pkg::REG_ROOT_SLOT, {24'h000000, root});
      n_settings++;
      send_request(make_ctl(hsd_pkg::KIND_RESTART));
   endtask

   // random traffic with sender gaps of varying length
   task run_phase(int count, int idle_pct, int restart_pct, bit mid_drain);
      for (int i = 0; i < count; i++) begin
         send_request(random_request(restart_pct));
         if (mid_drain && i == count / 2) begin
            drain_symbols();
         end else if (quiet_left > 0) begin
            quiet_left--;
         end else if ($urandom_range(99) < 4) begin
            quiet_left = $urandom_range(5, 15);
         end else if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   endtask

   initial begin
      sb = new();
      reset           <= 1'b1;
      start           <= 1'b0;
      req_kind        <= hsd_pkg::KIND_LOAD;
      req_node_slot   <= '0;
      req_leaf_mark   <= 1'b0;
      req_leaf_symbol <= '0;
      req_zero_branch <= '0;
      req_one_branch  <= '0;
      req_stream_byte <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      write_register(hsd_pkg::REG_SYMBOL_TOTAL, {8'h00, TOTAL_MAX});
      write_register(hsd_pkg::REG_ROOT_SLOT, '0);
      n_settings++;

      // every window slot gets written and children stay in the window,
      // so no walk can reach an empty entry
      for (int s = 0; s < TREE_SLOTS; s++)
         send_request(make_load(tree_slot(s), $urandom_range(99) < 45,
                                8'($urandom_range(255)), random_slot(), random_slot()));

      // small tree: 0 -> 00, 10 -> ff, 11 -> a5
      send_request(make_load(8'd0, 1'b0, 8'h00, 8'd1, 8'd2));
      send_request(make_load(8'd1, 1'b1, 8'h00, 8'hFF, 8'hFF));
      send_request(make_load(8'd2, 1'b0, 8'hFF, 8'd3, 8'd255));
      send_request(make_load(8'd3, 1'b1, 8'hFF, 8'h00, 8'h00));
      send_request(make_load(8'd255, 1'b1, 8'hA5, 8'h00, 8'h00));
      send_request(make_byte(8'h00));   // eight symbols from one byte
      send_request(make_byte(8'hFF));
      send_request(make_byte(8'hAA));
      send_request(make_byte(8'h55));   // ends mid-code
      send_request(make_byte(8'h80));   // code finished across the byte edge
      send_request(make_byte(8'h01));   // leaves the walker on slot 2

      // reload the node under the walker as a leaf: bits get dropped
      send_request(make_load(8'd2, 1'b1, 8'h3C, 8'h00, 8'h00));
      send_request(make_byte(8'h00));
      send_request(make_ctl(hsd_pkg::KIND_RESTART));
      send_request(make_byte(8'hF0));
      send_request(make_ctl(KIND_UNUSED));

      // root that is itself a leaf decodes nothing
      drain_symbols();
      write_register(hsd_pkg::REG_ROOT_SLOT, 32'd1);
      send_request(make_byte(8'h5A));

      // stop after three symbols, restart resumes
      drain_symbols();
      write_register(hsd_pkg::REG_ROOT_SLOT, '0);
      write_register(hsd_pkg::REG_SYMBOL_TOTAL, 32'd3);
      n_settings++;
      send_request(make_ctl(hsd_pkg::KIND_RESTART));
      send_request(make_byte(8'h00));
      send_request(make_byte(8'h00));
      send_request(make_ctl(hsd_pkg::KIND_RESTART));
      send_request(make_byte(8'h00));

      // zero total decodes nothing
      drain_symbols();
      write_register(hsd_pkg::REG_SYMBOL_TOTAL, '0);
      n_settings++;
      send_request(make_byte(8'hFF));

      // random phases
      configure(TOTAL_MAX, pick_internal_root());
      run_phase(45, 0, 6, 1'b1);
      configure(24'd1, pick_internal_root());
      run_phase(40, 86, 30, 1'b0);
      configure(24'($urandom_range(8, 40)), pick_internal_root());
      run_phase(40, 0, 12, 1'b0);
      configure(24'd0, random_slot());
      run_phase(25, 33, 8, 1'b0);
      drain_symbols();
      send_request(make_load(8'd255, 1'b0, 8'($urandom_range(255)), random_slot(),
                             random_slot()));
      configure(24'($urandom_range(1000, 16777214)), 8'd255);
      run_phase(40, 86, 6, 1'b0);
      drain_symbols();

      $display("run covered %0d requests: %0d bytes, %0d loads, %0d restarts",
               n_requests, n_bytes, n_loads, n_restarts);
      $display("%0d decoded symbols checked over %0d register settings, %0d mismatches",
               sb.symbols_checked, n_settings, sb.fail_count);
      if (sb.fail_count == 0) begin
         $display("PASS huffman_stream_decoder_top");
      end else begin
         $display("FAIL huffman_stream_decoder_top");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/hsd_pkg.sv
hdl/hsd_csr.sv
hdl/hsd_ctrl.sv
hdl/hsd_datapath.sv
hdl/huffman_stream_decoder_top.sv
hdl/hsd_checker.sv
verif/tb_huffman_stream_decoder_top.sv
